// File: design/cpgb_pkg.sv
package cpgb_pkg;

  localparam int COORD_W   = 16;
  localparam int COLOR_W   = 16;
  localparam int DIM_W     = 8;
  localparam int SCR_W     = 12;
  localparam int NIB_W     = 4;
  localparam int PAL_AW    = NIB_W;
  localparam int PAL_DEPTH = 1 << PAL_AW;
  localparam int MODE_W    = 2;
  localparam int CFG_IDX_W = 2;

  localparam logic [MODE_W-1:0] MODE_PALETTE = 2'd0;
  localparam logic [MODE_W-1:0] MODE_GLYPH   = 2'd1;
  localparam logic [MODE_W-1:0] MODE_DATA    = 2'd2;

  localparam logic KIND_PIXEL   = 1'b0;
  localparam logic KIND_ADVANCE = 1'b1;

  localparam logic [CFG_IDX_W-1:0] CFG_SCREEN_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SCREEN_HEIGHT = 2'd1;

  localparam logic [SCR_W-1:0] SCREEN_WIDTH_RST  = 12'd320;
  localparam logic [SCR_W-1:0] SCREEN_HEIGHT_RST = 12'd240;

  localparam logic [DIM_W-1:0] ROW_MAX = 8'hff;

  typedef struct packed {
    logic              we;
    logic [PAL_AW-1:0] waddr;
    logic [COLOR_W-1:0] wdata;
    logic              re;
    logic [PAL_AW-1:0] raddr0;
    logic [PAL_AW-1:0] raddr1;
  } pal_req_t;

  typedef struct packed {
    logic [COLOR_W-1:0] rdata0;
    logic [COLOR_W-1:0] rdata1;
  } pal_rsp_t;

  typedef struct packed {
    logic             emit;
    logic [DIM_W-1:0] col;
    logic [DIM_W-1:0] row;
  } walk_step_t;

  // One nibble of the column/row walk; stride zero freezes the walk.
  function automatic walk_step_t walk_step(
    input logic [DIM_W-1:0] col,
    input logic [DIM_W-1:0] row,
    input logic [DIM_W-1:0] stride,
    input logic [DIM_W-1:0] clip_w,
    input logic [DIM_W-1:0] clip_h
  );
    walk_step_t s;
    logic [DIM_W:0] col_inc;
    s.emit  = 1'b0;
    s.col   = col;
    s.row   = row;
    col_inc = {1'b0, col} + {{DIM_W{1'b0}}, 1'b1};
    if (stride != '0) begin
      s.emit = (col < clip_w) && (row < clip_h);
      if (col_inc >= {1'b0, stride}) begin
        s.col = '0;
        if (row != ROW_MAX) begin
          s.row = row + {{(DIM_W-1){1'b0}}, 1'b1};
        end
      end else begin
        s.col = col_inc[DIM_W-1:0];
      end
    end
    return s;
  endfunction

  // Clip a span against an edge; zero when it starts past the edge.
  function automatic logic [DIM_W-1:0] clip_len(
    input logic [COORD_W-1:0] start,
    input logic [DIM_W-1:0]   len,
    input logic [SCR_W-1:0]   edge_pos
  );
    logic signed [COORD_W+1:0] s;
    logic signed [COORD_W+1:0] e;
    logic signed [COORD_W+1:0] sum;
    logic signed [COORD_W+1:0] diff;
    logic [DIM_W-1:0] r;
    s    = $signed({{2{start[COORD_W-1]}}, start});
    e    = $signed({{(COORD_W+2-SCR_W){1'b0}}, edge_pos});
    sum  = s + $signed({{(COORD_W+2-DIM_W){1'b0}}, len});
    diff = e - s;
    if (sum <= e) begin
      r = len;
    end else if (diff < 0) begin
      r = '0;
    end else begin
      r = diff[DIM_W-1:0];
    end
    return r;
  endfunction

endpackage

// File: design/cpgb_in_if.sv
interface cpgb_in_if;
  logic                                   valid;
  logic                                   ready;
  logic [cpgb_pkg::MODE_W-1:0]            mode;
  logic signed [cpgb_pkg::COORD_W-1:0]    pos_x;
  logic signed [cpgb_pkg::COORD_W-1:0]    pos_y;
  logic [cpgb_pkg::DIM_W-1:0]             glyph_width;
  logic [cpgb_pkg::DIM_W-1:0]             glyph_height;
  logic signed [cpgb_pkg::DIM_W-1:0]      glyph_yoffset;
  logic [2*cpgb_pkg::NIB_W-1:0]           data_byte;
  logic [cpgb_pkg::PAL_AW-1:0]            palette_index;
  logic [cpgb_pkg::COLOR_W-1:0]           palette_color;

  modport source (
    output valid, mode, pos_x, pos_y, glyph_width, glyph_height, glyph_yoffset,
           data_byte, palette_index, palette_color,
    input  ready
  );
  modport sink (
    input  valid, mode, pos_x, pos_y, glyph_width, glyph_height, glyph_yoffset,
           data_byte, palette_index, palette_color,
    output ready
  );
endinterface

// File: design/cpgb_out_if.sv
interface cpgb_out_if;
  logic                                valid;
  logic                                ready;
  logic                                kind;
  logic signed [cpgb_pkg::COORD_W-1:0] pixel_x;
  logic signed [cpgb_pkg::COORD_W-1:0] pixel_y;
  logic [cpgb_pkg::COLOR_W-1:0]        pixel_color;
  logic                                last;

  modport source (
    output valid, kind, pixel_x, pixel_y, pixel_color, last,
    input  ready
  );
  modport sink (
    input  valid, kind, pixel_x, pixel_y, pixel_color, last,
    output ready
  );
endinterface

// File: design/cpgb_cfg_if.sv
interface cpgb_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [cpgb_pkg::CFG_IDX_W-1:0] index;
  logic [cpgb_pkg::SCR_W-1:0]     data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// File: design/cpgb_palette.sv
module cpgb_palette (
  input  logic               clk,
  input  cpgb_pkg::pal_req_t req,
  output cpgb_pkg::pal_rsp_t rsp
);
  import cpgb_pkg::*;

  logic [COLOR_W-1:0] mem [PAL_DEPTH];
  pal_rsp_t           rsp_r;

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr] <= req.wdata;
    end
  end

  // Hold read data until the next read so a draining beat keeps its colors.
  always_ff @(posedge clk) begin
    if (req.re) begin
      rsp_r.rdata0 <= mem[req.raddr0];
      rsp_r.rdata1 <= mem[req.raddr1];
    end
  end

  assign rsp = rsp_r;

endmodule

// File: design/clipped_palette_glyph_blitter_core.sv
// The first result beat is registered: an accepted input beat loads the pending
// slots, then a drain loads the output register unless the output stalls.
// A data byte with two pixels holds off new input until the single result port
// has drained both pixel slots. Palette reads use the RAM's registered read ports.
// Reset (rst_n low, synchronous): screen 320x240, glyph state and walk zero,
// no pending results; palette contents are not cleared.
module clipped_palette_glyph_blitter_core (
  input  logic      clk,
  input  logic      rst_n,
  cpgb_in_if.sink   in_ch,
  cpgb_out_if.source out_ch,
  cpgb_cfg_if.sink  cfg_ch
);
  import cpgb_pkg::*;

  logic [SCR_W-1:0]   scr_w_r, scr_h_r;
  logic [COORD_W-1:0] origin_col_r, origin_row_r;
  logic [DIM_W-1:0]   stride_r, clip_w_r, clip_h_r;
  logic [DIM_W-1:0]   wcol_r, wrow_r;

  logic [1:0]         pend_r, pend_nxt, pend_drained;
  logic               adv_slot_r;
  logic [DIM_W-1:0]   adv_r;
  logic [COORD_W-1:0] x0_r, y0_r, x1_r, y1_r;

  logic               out_valid_r, out_kind_r, out_last_r;
  logic [COORD_W-1:0] out_x_r, out_y_r;
  logic [COLOR_W-1:0] out_color_r;

  logic               acc, load_out, sel1, is_adv;
  logic [COORD_W-1:0] yr;
  walk_step_t         step0, step1;
  pal_req_t           pal_req;
  pal_rsp_t           pal_rsp;

  cpgb_palette u_palette (
    .clk (clk),
    .req (pal_req),
    .rsp (pal_rsp)
  );

  assign acc = in_ch.valid && in_ch.ready;

  always_comb begin
    pal_req.we     = acc && (in_ch.mode == MODE_PALETTE);
    pal_req.waddr  = in_ch.palette_index;
    pal_req.wdata  = in_ch.palette_color;
    pal_req.re     = acc && (in_ch.mode == MODE_DATA);
    pal_req.raddr0 = in_ch.data_byte[NIB_W-1:0];
    pal_req.raddr1 = in_ch.data_byte[2*NIB_W-1:NIB_W];
  end

  assign step0 = walk_step(wcol_r, wrow_r, stride_r, clip_w_r, clip_h_r);
  assign step1 = walk_step(step0.col, step0.row, stride_r, clip_w_r, clip_h_r);

  assign yr = $unsigned(in_ch.pos_y)
            + {{(COORD_W-DIM_W){in_ch.glyph_yoffset[DIM_W-1]}}, $unsigned(in_ch.glyph_yoffset)};

  // Drain pending slots lowest first, one beat per cycle unless the output stalls.
  assign load_out = (pend_r != 2'b00) && (!out_valid_r || out_ch.ready);
  assign sel1     = !pend_r[0];
  assign is_adv   = !sel1 && adv_slot_r;

  always_comb begin
    pend_drained = pend_r;
    if (load_out) begin
      pend_drained = pend_r[0] ? {pend_r[1], 1'b0} : 2'b00;
    end
  end

  assign in_ch.ready = (pend_drained == 2'b00);

  always_comb begin
    pend_nxt = pend_drained;
    if (acc) begin
      if (in_ch.mode == MODE_GLYPH) begin
        pend_nxt = 2'b01;
      end else if (in_ch.mode == MODE_DATA) begin
        pend_nxt = {step1.emit, step0.emit};
      end else begin
        pend_nxt = 2'b00;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scr_w_r      <= SCREEN_WIDTH_RST;
      scr_h_r      <= SCREEN_HEIGHT_RST;
      origin_col_r <= '0;
      origin_row_r <= '0;
      stride_r     <= '0;
      clip_w_r     <= '0;
      clip_h_r     <= '0;
      wcol_r       <= '0;
      wrow_r       <= '0;
      pend_r       <= 2'b00;
      out_valid_r  <= 1'b0;
    end else begin
      pend_r <= pend_nxt;

      if (cfg_ch.valid && cfg_ch.ready) begin
        unique case (cfg_ch.index)
          CFG_SCREEN_WIDTH:  scr_w_r <= cfg_ch.data;
          CFG_SCREEN_HEIGHT: scr_h_r <= cfg_ch.data;
          default: ;
        endcase
      end

      if (acc && (in_ch.mode == MODE_GLYPH)) begin
        origin_col_r <= $unsigned(in_ch.pos_x);
        origin_row_r <= yr;
        stride_r     <= in_ch.glyph_width;
        clip_w_r     <= clip_len($unsigned(in_ch.pos_x), in_ch.glyph_width, scr_w_r);
        clip_h_r     <= clip_len(yr, in_ch.glyph_height, scr_h_r);
        wcol_r       <= '0;
        wrow_r       <= '0;
      end else if (acc && (in_ch.mode == MODE_DATA)) begin
        wcol_r <= step1.col;
        wrow_r <= step1.row;
      end

      if (load_out) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Slot payload; no reset needed.
  always_ff @(posedge clk) begin
    if (acc) begin
      adv_slot_r <= (in_ch.mode == MODE_GLYPH);
      adv_r      <= in_ch.glyph_width;
      x0_r       <= origin_col_r + {{(COORD_W-DIM_W){1'b0}}, wcol_r};
      y0_r       <= origin_row_r + {{(COORD_W-DIM_W){1'b0}}, wrow_r};
      x1_r       <= origin_col_r + {{(COORD_W-DIM_W){1'b0}}, step0.col};
      y1_r       <= origin_row_r + {{(COORD_W-DIM_W){1'b0}}, step0.row};
    end
    if (load_out) begin
      out_kind_r  <= is_adv ? KIND_ADVANCE : KIND_PIXEL;
      out_x_r     <= is_adv ? '0 : (sel1 ? x1_r : x0_r);
      out_y_r     <= is_adv ? '0 : (sel1 ? y1_r : y0_r);
      out_color_r <= is_adv ? {{(COLOR_W-DIM_W){1'b0}}, adv_r}
                            : (sel1 ? pal_rsp.rdata1 : pal_rsp.rdata0);
      out_last_r  <= (pend_drained == 2'b00);
    end
  end

  assign cfg_ch.ready       = 1'b1;
  assign out_ch.valid       = out_valid_r;
  assign out_ch.kind        = out_kind_r;
  assign out_ch.pixel_x     = $signed(out_x_r);
  assign out_ch.pixel_y     = $signed(out_y_r);
  assign out_ch.pixel_color = out_color_r;
  assign out_ch.last        = out_last_r;

endmodule
